FILE: hw/rtl/pdc_pkg.sv
// ----------------------------------------------------------------------------
// pdc_pkg
// Shared constants for the clamped PID controller with deadzone.
// ----------------------------------------------------------------------------
package pdc_pkg;

    localparam int PDC_FRAC_BITS  = 8;
    localparam int PDC_PROD_SHIFT = 2 * PDC_FRAC_BITS;

    localparam int PDC_IDX_W = 3;
    localparam int PDC_CFG_W = 23;

    localparam logic [PDC_IDX_W-1:0] PDC_REG_GAIN_P    = 3'd0;
    localparam logic [PDC_IDX_W-1:0] PDC_REG_GAIN_I    = 3'd1;
    localparam logic [PDC_IDX_W-1:0] PDC_REG_GAIN_D    = 3'd2;
    localparam logic [PDC_IDX_W-1:0] PDC_REG_DEAD_BAND = 3'd3;
    localparam logic [PDC_IDX_W-1:0] PDC_REG_INT_LIMIT = 3'd4;
    localparam logic [PDC_IDX_W-1:0] PDC_REG_OUT_LIMIT = 3'd5;

    localparam logic [15:0] PDC_RST_GAIN_P    = 16'd12800;
    localparam logic [15:0] PDC_RST_GAIN_I    = 16'd0;
    localparam logic [15:0] PDC_RST_GAIN_D    = 16'd2560;
    localparam logic [15:0] PDC_RST_DEAD_BAND = 16'd26;
    localparam logic [22:0] PDC_RST_INT_LIMIT = 23'd256000;
    localparam logic [14:0] PDC_RST_OUT_LIMIT = 15'd16700;

endpackage

FILE: hw/rtl/pid_deadzone_clamped_core.sv
// ----------------------------------------------------------------------------
// pid_deadzone_clamped_core
// Positional PID with integral clamp, deadzone and symmetric output clamp.
// ----------------------------------------------------------------------------
//  channel   | direction | word
//  s_*       | in        | tdata[23:0] target_value, [47:24] measured_value
//  m_*       | out       | tdata[15:0] drive
//  cfg_*     | in        | write only, index 0..5, others ignored
//
//  Four register ranks: input, error/integral, products, result.
//  One word per cycle sustained while m_tready stays high.
//  Integral and previous error update as a word leaves the input rank.
//  Each rank holds only while the next is full and cannot move on, so bubbles are absorbed on stalls.
//  aresetn is synchronous; it clears valids, state and config to defaults.
// ----------------------------------------------------------------------------
module pid_deadzone_clamped_core
    import pdc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [47:0]          s_tdata,   // target_value, measured_value

    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata,   // drive

    input  logic                 cfg_we,
    input  logic [PDC_IDX_W-1:0] cfg_index,
    input  logic [PDC_CFG_W-1:0] cfg_wdata
);

    logic [15:0] gain_p_reg, gain_i_reg, gain_d_reg, dead_band_reg;
    logic [22:0] int_limit_reg;
    logic [14:0] out_limit_reg;

    logic v0_reg, v1_reg, v2_reg, v3_reg;
    logic ready1, ready2, ready3;
    logic ld0, ld1, ld2, ld3;

    logic signed [23:0] tgt_reg, meas_reg;
    logic signed [23:0] error_sum_reg, error_sum_next;
    logic signed [24:0] prev_err_reg, prev_err_next;

    logic signed [24:0] err;
    logic signed [25:0] sum_wide, lim_pos, lim_neg;
    logic        [24:0] err_mag;
    logic signed [25:0] diff_next;

    logic signed [24:0] ez1_reg;
    logic signed [23:0] es1_reg;
    logic signed [25:0] diff1_reg;

    logic signed [16:0] gp_s, gi_s, gd_s;
    logic signed [41:0] prod_p_next, prod_p_reg;
    logic signed [40:0] prod_i_next, prod_i_reg;
    logic signed [42:0] prod_d_next, prod_d_reg;

    logic signed [44:0] acc;
    logic        [44:0] acc_mag, acc_sh;
    logic        [14:0] mag_clamped;
    logic signed [15:0] drive_next, drive_reg;

    // handshake chain
    assign ready3   = !v3_reg || m_tready;
    assign ready2   = !v2_reg || ready3;
    assign ready1   = !v1_reg || ready2;
    assign s_tready = !v0_reg || ready1;

    assign ld0 = s_tvalid && s_tready;
    assign ld1 = v0_reg && ready1;
    assign ld2 = v1_reg && ready2;
    assign ld3 = v2_reg && ready3;

    assign m_tvalid = v3_reg;
    assign m_tdata  = drive_reg;

    // error, integral clamp, deadzone
    always_comb begin
        err      = 25'(tgt_reg) - 25'(meas_reg);
        sum_wide = 26'(error_sum_reg) + 26'(err);
        lim_pos  = signed'({3'b000, int_limit_reg});
        lim_neg  = -lim_pos;
        priority if (sum_wide > lim_pos) begin
            error_sum_next = lim_pos[23:0];
        end else if (sum_wide < lim_neg) begin
            error_sum_next = lim_neg[23:0];
        end else begin
            error_sum_next = sum_wide[23:0];
        end
        err_mag = err[24] ? 25'(-err) : 25'(err);
        if (err_mag < {9'b0, dead_band_reg}) begin
            prev_err_next = '0;
        end else begin
            prev_err_next = err;
        end
        diff_next = 26'(prev_err_next) - 26'(prev_err_reg);
    end

    // products
    assign gp_s = signed'({1'b0, gain_p_reg});
    assign gi_s = signed'({1'b0, gain_i_reg});
    assign gd_s = signed'({1'b0, gain_d_reg});
    assign prod_p_next = gp_s * ez1_reg;
    assign prod_i_next = gi_s * es1_reg;
    assign prod_d_next = gd_s * diff1_reg;

    // sum, truncate toward zero, clamp
    always_comb begin
        acc     = 45'(prod_p_reg) + 45'(prod_i_reg) + 45'(prod_d_reg);
        acc_mag = acc[44] ? 45'(-acc) : 45'(acc);
        acc_sh  = acc_mag >> PDC_PROD_SHIFT;
        if (acc_sh > {30'b0, out_limit_reg}) begin
            mag_clamped = out_limit_reg;
        end else begin
            mag_clamped = acc_sh[14:0];
        end
        drive_next = acc[44] ? -signed'({1'b0, mag_clamped})
                             : signed'({1'b0, mag_clamped});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_p_reg    <= PDC_RST_GAIN_P;
            gain_i_reg    <= PDC_RST_GAIN_I;
            gain_d_reg    <= PDC_RST_GAIN_D;
            dead_band_reg <= PDC_RST_DEAD_BAND;
            int_limit_reg <= PDC_RST_INT_LIMIT;
            out_limit_reg <= PDC_RST_OUT_LIMIT;
        end else if (cfg_we) begin
            unique case (cfg_index)
                PDC_REG_GAIN_P:    gain_p_reg    <= cfg_wdata[15:0];
                PDC_REG_GAIN_I:    gain_i_reg    <= cfg_wdata[15:0];
                PDC_REG_GAIN_D:    gain_d_reg    <= cfg_wdata[15:0];
                PDC_REG_DEAD_BAND: dead_band_reg <= cfg_wdata[15:0];
                PDC_REG_INT_LIMIT: int_limit_reg <= cfg_wdata[22:0];
                PDC_REG_OUT_LIMIT: out_limit_reg <= cfg_wdata[14:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg        <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            error_sum_reg <= '0;
            prev_err_reg  <= '0;
        end else begin
            v0_reg <= ld0 || (v0_reg && !ld1);
            v1_reg <= ld1 || (v1_reg && !ld2);
            v2_reg <= ld2 || (v2_reg && !ld3);
            v3_reg <= ld3 || (v3_reg && !m_tready);
            if (ld1) begin
                error_sum_reg <= error_sum_next;
                prev_err_reg  <= prev_err_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ld0) begin
            tgt_reg  <= signed'(s_tdata[23:0]);
            meas_reg <= signed'(s_tdata[47:24]);
        end
        if (ld1) begin
            ez1_reg   <= prev_err_next;
            es1_reg   <= error_sum_next;
            diff1_reg <= diff_next;
        end
        if (ld2) begin
            prod_p_reg <= prod_p_next;
            prod_i_reg <= prod_i_next;
            prod_d_reg <= prod_d_next;
        end
        if (ld3) begin
            drive_reg <= drive_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_int_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        ld1 |=> (26'(error_sum_reg) <= signed'({3'b000, $past(int_limit_reg)}))
             && (26'(error_sum_reg) >= -signed'({3'b000, $past(int_limit_reg)})))
        else $error("integral outside clamp");

    a_deadzone: assert property (@(posedge aclk) disable iff (!aresetn)
        ld1 |=> (prev_err_reg == '0)
             || ((prev_err_reg[24] ? 25'(-prev_err_reg) : 25'(prev_err_reg))
                 >= {9'b0, $past(dead_band_reg)}))
        else $error("previous error inside deadzone");

    a_out_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (drive_reg <= signed'({1'b0, out_limit_reg}))
                  && (drive_reg >= -signed'({1'b0, out_limit_reg})))
        else $error("drive outside output limit");
`endif

endmodule
